### rtl/core/sorted_list_match_scorer_assert.svh
// ----------------------------------------------------------------------------
// sorted_list_match_scorer_assert.svh
// Assertion macros for the match scorer. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_MATCH_SCORER_ASSERT_SVH
`define SORTED_LIST_MATCH_SCORER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// invariant that holds at every edge out of reset
`define SLMS_ASSERT_HOLDS(lbl, clk, rst_n, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
		else $error("slms: invariant violated");
// same-cycle implication
`define SLMS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("slms: implication violated");
// next-cycle implication
`define SLMS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("slms: next-cycle check violated");
`else
`define SLMS_ASSERT_HOLDS(lbl, clk, rst_n, c)
`define SLMS_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define SLMS_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

### rtl/core/slms_pkg.sv
// ----------------------------------------------------------------------------
// slms_pkg
// Shared widths, commands and types of the sorted list match scorer.
// ----------------------------------------------------------------------------
package slms_pkg;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned CNT_W       = 11;
	localparam int unsigned CAND_W      = 16;
	localparam int unsigned DIV_CNT_W   = $clog2(VAL_W + 1);
	localparam int unsigned MAX_REF_DEF = 1024;

	localparam logic [VAL_W-1:0]  QSTEP_RST = 32'h0001_0000;
	localparam logic [CAND_W-1:0] CAND_MAX  = 16'hFFFF;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CAND   = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/core/slms_in_if.sv
// ----------------------------------------------------------------------------
// slms_in_if
// Input channel: command, value and last mark with valid/ready.
// ----------------------------------------------------------------------------
interface slms_in_if;
	logic                          valid;
	logic                          ready;
	logic [slms_pkg::CMD_W-1:0]    cmd;
	logic [slms_pkg::VAL_W-1:0]    value;
	logic                          last;

	modport source (output valid, output cmd, output value, output last, input ready);
	modport sink   (input valid, input cmd, input value, input last, output ready);
endinterface

### rtl/core/slms_out_if.sv
// ----------------------------------------------------------------------------
// slms_out_if
// Result channel: match count, similar flag and list lengths with valid/ready.
// ----------------------------------------------------------------------------
interface slms_out_if;
	logic                          valid;
	logic                          ready;
	logic [slms_pkg::CNT_W-1:0]    match_count;
	logic                          similar;
	logic [slms_pkg::CNT_W-1:0]    ref_length;
	logic [slms_pkg::CAND_W-1:0]   cand_length;

	modport source (output valid, output match_count, output similar, output ref_length,
		output cand_length, input ready);
	modport sink   (input valid, input match_count, input similar, input ref_length,
		input cand_length, output ready);
endinterface

### rtl/core/slms_div.sv
// ----------------------------------------------------------------------------
// slms_div
// Restoring radix-2 divider, one quotient bit per cycle. A zero divisor
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module slms_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [slms_pkg::VAL_W-1:0]  dividend,
	input  logic [slms_pkg::VAL_W-1:0]  divisor,
	output logic [slms_pkg::VAL_W-1:0]  quotient,
	output slms_pkg::div_stat_t         stat
);

	localparam int unsigned W  = slms_pkg::VAL_W;
	localparam int unsigned CW = slms_pkg::DIV_CNT_W;

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

### rtl/core/slms_ref_mem.sv
// ----------------------------------------------------------------------------
// slms_ref_mem
// Reference key store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slms_ref_mem #(
	parameter int unsigned DEPTH = slms_pkg::MAX_REF_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [slms_pkg::VAL_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [slms_pkg::VAL_W-1:0]  rdata
);

	logic [slms_pkg::VAL_W-1:0] mem [DEPTH];
	logic [slms_pkg::VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/sorted_list_match_scorer.sv
// ----------------------------------------------------------------------------
// sorted_list_match_scorer
// Quantizes ascending reference and candidate lists and counts shared keys.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready): cmd, value, last. Clear empties the reference
//          list; append quantizes value and stores the key; candidate
//          quantizes value and merges it against the stored keys.
//   out_ch (valid/ready): one item per candidate list, on the item with last.
//   cfg_we/cfg_wdata: quantization step, written while the block is idle.
// Sequencing:
//   Clear, unused commands and a full-list append leave the state idle.
//   Append runs the shared 32-step divider, then stores the key; a
//   candidate runs it, then steps the pointer over the reference entries
//   (one store read and compare each) until the walk stops on a compare
//   inside the list or at its end. A result turns valid in the cycle the
//   block is ready again; the block waits while the receiver holds one.
//   One item at a time: in_ch.ready is high only while the sequencer idles.
// Reset: step returns to 1.0, reference list and merge state empty. The key
//   store itself is not cleared; only entries below the list length are used.
// Stall: the result sits in an output register; the block keeps accepting
//   items and only holds if a second result is due before the first is taken.
// ----------------------------------------------------------------------------
`include "sorted_list_match_scorer_assert.svh"

module sorted_list_match_scorer #(
	parameter int unsigned MAX_REF = slms_pkg::MAX_REF_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [slms_pkg::VAL_W-1:0]  cfg_wdata,
	slms_in_if.sink                     in_ch,
	slms_out_if.source                  out_ch
);

	localparam int unsigned AW = $clog2(MAX_REF);
	localparam int unsigned CW = $clog2(MAX_REF + 1);
	localparam int unsigned MW = (CW > slms_pkg::CAND_W) ? CW : slms_pkg::CAND_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [slms_pkg::VAL_W-1:0]    qstep_q;
	logic [slms_pkg::CMD_W-1:0]    cmd_q;
	logic                          last_q;
	logic [CW-1:0]                 ref_len_q;
	logic [CW-1:0]                 ref_ptr_q;
	logic [CW-1:0]                 matches_q;
	logic [slms_pkg::CAND_W-1:0]   cand_cnt_q;

	logic                          out_valid_q;
	logic [slms_pkg::CNT_W-1:0]    out_match_q;
	logic                          out_similar_q;
	logic [slms_pkg::CNT_W-1:0]    out_rlen_q;
	logic [slms_pkg::CAND_W-1:0]   out_clen_q;

	logic                          accept;
	logic                          div_start;
	logic                          mem_we;
	logic                          out_free;
	logic                          out_load;
	logic                          ref_full;
	logic [slms_pkg::VAL_W-1:0]    key;
	logic [slms_pkg::VAL_W-1:0]    rd_key;
	slms_pkg::div_stat_t           div_stat;

	logic [MW-1:0]                 shorter;
	logic [MW+2:0]                 lhs;
	logic [MW+2:0]                 rhs;
	logic                          similar;

	assign accept   = in_ch.valid && in_ch.ready;
	assign ref_full = (ref_len_q == CW'(MAX_REF));
	assign out_free = !out_valid_q || out_ch.ready;

	assign div_start = accept && ((in_ch.cmd == slms_pkg::CMD_CAND) ||
		((in_ch.cmd == slms_pkg::CMD_APPEND) && !ref_full));
	assign mem_we    = (state_q == ST_DIV) && div_stat.done && (cmd_q == slms_pkg::CMD_APPEND);
	assign out_load  = (state_q == ST_FIN) && last_q && out_free;

	// 5*m > 3*min(len, cnt) by shift-add
	assign shorter = (MW'(ref_len_q) < MW'(cand_cnt_q)) ? MW'(ref_len_q) : MW'(cand_cnt_q);
	assign lhs     = ((MW+3)'(matches_q) << 2) + (MW+3)'(matches_q);
	assign rhs     = ((MW+3)'(shorter) << 1) + (MW+3)'(shorter);
	assign similar = (shorter != '0) && (lhs > rhs);

	slms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_ch.value),
		.divisor  (qstep_q),
		.quotient (key),
		.stat     (div_stat)
	);

	slms_ref_mem #(
		.DEPTH (MAX_REF),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ref_len_q[AW-1:0]),
		.wdata (key),
		.raddr (ref_ptr_q[AW-1:0]),
		.rdata (rd_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qstep_q <= slms_pkg::QSTEP_RST;
		end else if (cfg_we) begin
			qstep_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_ch.cmd;
			last_q <= in_ch.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ref_len_q  <= '0;
			ref_ptr_q  <= '0;
			matches_q  <= '0;
			cand_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (in_ch.cmd == slms_pkg::CMD_CLEAR) begin
							ref_len_q  <= '0;
							ref_ptr_q  <= '0;
							matches_q  <= '0;
							cand_cnt_q <= '0;
						end else if (in_ch.cmd == slms_pkg::CMD_APPEND) begin
							if (!ref_full) begin
								state_q <= ST_DIV;
							end
						end else if (in_ch.cmd == slms_pkg::CMD_CAND) begin
							if (cand_cnt_q != slms_pkg::CAND_MAX) begin
								cand_cnt_q <= cand_cnt_q + slms_pkg::CAND_W'(1);
							end
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (cmd_q == slms_pkg::CMD_APPEND) begin
							ref_len_q <= ref_len_q + CW'(1);
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= (ref_ptr_q < ref_len_q) ? ST_CMP : ST_FIN;
				end
				ST_CMP: begin
					if (rd_key < key) begin
						ref_ptr_q <= ref_ptr_q + CW'(1);
						state_q   <= ST_RD;
					end else begin
						if (rd_key == key) begin
							matches_q <= matches_q + CW'(1);
							ref_ptr_q <= ref_ptr_q + CW'(1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						ref_ptr_q  <= '0;
						matches_q  <= '0;
						cand_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_match_q   <= slms_pkg::CNT_W'(matches_q);
			out_similar_q <= similar;
			out_rlen_q    <= slms_pkg::CNT_W'(ref_len_q);
			out_clen_q    <= cand_cnt_q;
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.match_count = out_match_q;
	assign out_ch.similar     = out_similar_q;
	assign out_ch.ref_length  = out_rlen_q;
	assign out_ch.cand_length = out_clen_q;

	`SLMS_ASSERT_HOLDS(a_ptr_in_list, clk, arst_n, ref_ptr_q <= ref_len_q)
	`SLMS_ASSERT_HOLDS(a_matches_le_ptr, clk, arst_n, matches_q <= ref_ptr_q)
	`SLMS_ASSERT_IMPL(a_ready_div_idle, clk, arst_n, in_ch.ready, !div_stat.busy)
	`SLMS_ASSERT_NEXT(a_result_clears, clk, arst_n, out_load,
		out_valid_q && (cand_cnt_q == '0) && (matches_q == '0))

endmodule
